@@ hdl/tdt_pkg.sv @@
// shared constants for the tile deduplication table
`default_nettype none
package tdt_pkg;
    localparam int DEF_MAX_TILES       = 256;
    localparam int DEF_MAX_CELL_PIXELS = 64;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_COMPARE  = 2'd3;

    localparam logic [6:0] RST_CELL_PIXELS = 7'd64;
    localparam logic [8:0] RST_TABLE_LIMIT = 9'd256;

    localparam int CODE_W      = 16;
    localparam int CODE_IDX_W  = 14;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
endpackage
`default_nettype wire

@@ hdl/tdt_tile_mem.sv @@
// stored tile words, slot zero reads as the all-zero tile
`default_nettype none
module tdt_tile_mem #(
    parameter int SLOT_W = 8,
    parameter int WORD_W = 6
) (
    input  wire logic                       clk,
    input  wire logic [SLOT_W-1:0]          rd_slot,
    input  wire logic [WORD_W-1:0]          rd_word,
    input  wire logic                       wr_en,
    input  wire logic [SLOT_W-1:0]          wr_slot,
    input  wire logic [WORD_W-1:0]          wr_word,
    input  wire logic [31:0]                wr_data,
    output logic      [31:0]                rd_data
);
    localparam int DEPTH = 2 ** (SLOT_W + WORD_W);

    logic [31:0] mem [DEPTH];
    logic [31:0] raw_reg;
    logic        zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_slot, wr_word}] <= wr_data;
        end
        raw_reg  <= mem[{rd_slot, rd_word}];
        zero_reg <= (rd_slot == '0);
    end

    assign rd_data = zero_reg ? 32'd0 : raw_reg;
endmodule
`default_nettype wire

@@ hdl/tile_dedup_table.sv @@
// tile deduplication table: collects one tile of argb pixels, then searches the
// stored tiles (unless compare is off) and stores new ones, emitting one tile code
// per completed tile. a completed tile holds off input while the search walks the
// stored slots word by word through the tile memory port, S_RD then S_CMP for each
// word; a slot is left at its first mismatching word, and a match ends the search.
// a new tile is copied into its slot word by word, S_CPR then S_CPW. the result goes
// to an output register, so pixels of the next tile are accepted while it waits.
// no clearing pass after reset.
`default_nettype none
module tile_dedup_table #(
    parameter int MAX_TILES       = tdt_pkg::DEF_MAX_TILES,
    parameter int MAX_CELL_PIXELS = tdt_pkg::DEF_MAX_CELL_PIXELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [31:0]                   pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        tile_code,
    output logic                               table_overflow,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tdt_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tdt_pkg::*;

    localparam int SW  = (MAX_TILES > 2) ? $clog2(MAX_TILES) : 1;
    localparam int TW  = $clog2(MAX_TILES + 1);
    localparam int WW  = (MAX_CELL_PIXELS > 1) ? $clog2(MAX_CELL_PIXELS) : 1;
    localparam int CW  = $clog2(MAX_CELL_PIXELS + 1);
    localparam int EW  = (CW > 7) ? CW : 7;
    localparam int LW  = (TW > 9) ? TW : 9;

    typedef enum logic [2:0] {
        S_ACC, S_RD, S_CMP, S_CODE, S_DECIDE, S_CPR, S_CPW, S_OUT
    } state_t;

    state_t        state_reg;
    logic [6:0]    cell_pixels_reg;
    logic [8:0]    table_limit_reg;
    logic          attr_reg;
    logic [1:0]    mode_reg;
    logic [TW-1:0] count_reg;
    logic [EW-1:0] cnt_reg;
    logic          vis_reg, opq_reg, part_reg;
    logic [TW-1:0] slot_reg;
    logic [EW-1:0] word_reg;
    logic [15:0]   res_code_reg;
    logic          res_ovf_reg;
    logic          out_valid_reg;
    logic [15:0]   out_code_reg;
    logic          out_ovf_reg;

    logic [31:0]   stg_mem [2 ** WW];
    logic [31:0]   stg_rdata;
    logic [15:0]   code_mem [2 ** SW];
    logic [15:0]   code_rdata;
    logic [31:0]   tile_rdata;

    logic [EW-1:0] cp_ext, eff_cp, cnt_next, word_next;
    logic [TW-1:0] slot_next;
    logic [7:0]    alpha;
    logic          vis_n, opq_n, part_n;
    logic          pix_acc, stg_we, tile_we, code_we;
    logic [WW-1:0] stg_raddr;
    logic [31:0]   copy_data;
    logic [15:0]   new_code;

    assign cp_ext    = EW'(cell_pixels_reg);
    assign eff_cp    = (cp_ext == '0) ? EW'(1) :
                       ((cp_ext > EW'(MAX_CELL_PIXELS)) ? EW'(MAX_CELL_PIXELS) : cp_ext);
    assign cnt_next  = cnt_reg + EW'(1);
    assign word_next = word_reg + EW'(1);
    assign slot_next = slot_reg + TW'(1);
    assign alpha     = pixel[31:24];
    assign vis_n     = vis_reg | (alpha != 8'd0);
    assign opq_n     = opq_reg & (alpha == ALPHA_OPAQUE);
    assign part_n    = part_reg | ((alpha != 8'd0) && (alpha != ALPHA_OPAQUE));

    assign in_ready  = (state_reg == S_ACC);
    assign cfg_ready = 1'b1;
    assign pix_acc   = in_valid && in_ready && !op;
    assign stg_we    = pix_acc;
    assign stg_raddr = word_reg[WW-1:0];
    assign tile_we   = (state_reg == S_CPW);
    assign code_we   = (state_reg == S_CPW) && (word_reg == EW'(MAX_CELL_PIXELS - 1));
    assign copy_data = (word_reg < eff_cp) ? stg_rdata : 32'd0;
    assign new_code  = {attr_reg & opq_reg, attr_reg & part_reg, CODE_IDX_W'(count_reg)};

    assign out_valid      = out_valid_reg;
    assign tile_code      = out_code_reg;
    assign table_overflow = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[cnt_reg[WW-1:0]] <= pixel;
        end
        stg_rdata <= stg_mem[stg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[count_reg[SW-1:0]] <= new_code;
        end
        code_rdata <= code_mem[slot_reg[SW-1:0]];
    end

    tdt_tile_mem #(
        .SLOT_W (SW),
        .WORD_W (WW)
    ) u_tile_mem (
        .clk     (clk),
        .rd_slot (slot_reg[SW-1:0]),
        .rd_word (word_reg[WW-1:0]),
        .wr_en   (tile_we),
        .wr_slot (count_reg[SW-1:0]),
        .wr_word (word_reg[WW-1:0]),
        .wr_data (copy_data),
        .rd_data (tile_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_ACC;
            cell_pixels_reg <= RST_CELL_PIXELS;
            table_limit_reg <= RST_TABLE_LIMIT;
            attr_reg        <= 1'b0;
            mode_reg        <= 2'd0;
            count_reg       <= TW'(1);
            cnt_reg         <= '0;
            vis_reg         <= 1'b0;
            opq_reg         <= 1'b1;
            part_reg        <= 1'b0;
            slot_reg        <= '0;
            word_reg        <= '0;
            res_code_reg    <= '0;
            res_ovf_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_code_reg    <= '0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CELL_PIXELS: cell_pixels_reg <= cfg_data[6:0];
                    CFG_TABLE_LIMIT: table_limit_reg <= cfg_data[8:0];
                    CFG_ATTR_ENABLE: attr_reg        <= cfg_data[0];
                    CFG_NO_COMPARE:  mode_reg        <= cfg_data[1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_ACC:
                begin
                    if (in_valid && op)
                    begin
                        count_reg <= TW'(1);
                        cnt_reg   <= '0;
                        vis_reg   <= 1'b0;
                        opq_reg   <= 1'b1;
                        part_reg  <= 1'b0;
                    end
                    else if (pix_acc)
                    begin
                        vis_reg  <= vis_n;
                        opq_reg  <= opq_n;
                        part_reg <= part_n;
                        if (cnt_next >= eff_cp)
                        begin
                            cnt_reg  <= '0;
                            slot_reg <= '0;
                            word_reg <= '0;
                            state_reg <= (mode_reg == 2'd0) ? S_RD : S_DECIDE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_next;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (tile_rdata != stg_rdata)
                    begin
                        slot_reg  <= slot_next;
                        word_reg  <= '0;
                        state_reg <= (slot_next == count_reg) ? S_DECIDE : S_RD;
                    end
                    else if (word_next >= eff_cp)
                    begin
                        state_reg <= S_CODE;
                    end
                    else
                    begin
                        word_reg  <= word_next;
                        state_reg <= S_RD;
                    end
                end
                S_CODE:
                begin
                    // slot zero is the blank tile with code zero
                    res_code_reg <= (slot_reg == '0) ? 16'd0 : code_rdata;
                    res_ovf_reg  <= 1'b0;
                    state_reg    <= S_OUT;
                end
                S_DECIDE:
                begin
                    word_reg <= '0;
                    if (!vis_reg && !mode_reg[1])
                    begin
                        res_code_reg <= 16'd0;
                        res_ovf_reg  <= 1'b0;
                        state_reg    <= S_OUT;
                    end
                    else if ((LW'(count_reg) >= LW'(table_limit_reg)) ||
                             (count_reg >= TW'(MAX_TILES)))
                    begin
                        res_code_reg <= 16'd0;
                        res_ovf_reg  <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_CPR;
                    end
                end
                S_CPR:
                begin
                    state_reg <= S_CPW;
                end
                S_CPW:
                begin
                    if (word_reg == EW'(MAX_CELL_PIXELS - 1))
                    begin
                        res_code_reg <= new_code;
                        res_ovf_reg  <= 1'b0;
                        count_reg    <= count_reg + TW'(1);
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        word_reg  <= word_next;
                        state_reg <= S_CPR;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_code_reg  <= res_code_reg;
                        out_ovf_reg   <= res_ovf_reg;
                        vis_reg       <= 1'b0;
                        opq_reg       <= 1'b1;
                        part_reg      <= 1'b0;
                        state_reg     <= S_ACC;
                    end
                end
                default:
                begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ dv/tile_dedup_table_tb.sv @@
// testbench for the tile deduplication table: predicted tile codes vs. the block
`timescale 1ns / 1ps
module tile_dedup_table_tb;
    import tdt_pkg::*;

    localparam bit OP_PIXEL   = 1'b0;
    localparam bit OP_RESTART = 1'b1;
    localparam int SLOTS      = DEF_MAX_TILES;
    localparam int CELL_MAX   = DEF_MAX_CELL_PIXELS;

    typedef struct packed {
        logic [15:0] code;
        logic        overflow;
    } tile_result_t;

    class tile_code_board;
        bit [31:0]    slot_px[SLOTS][CELL_MAX];
        bit [15:0]    slot_code[SLOTS];
        int unsigned  stored;
        bit [31:0]    stage[CELL_MAX];
        int unsigned  fill;
        bit           visible, opaque, partial;
        bit [6:0]     cell_reg;
        bit [8:0]     limit_reg;
        bit           attr_reg;
        bit [1:0]     mode_reg;
        tile_result_t pending_codes[$];
        int           errors;

        function new();
            foreach (slot_px[n, i]) slot_px[n][i] = '0;
            foreach (slot_code[n]) slot_code[n] = '0;
            stored    = 1;
            cell_reg  = RST_CELL_PIXELS;
            limit_reg = RST_TABLE_LIMIT;
            attr_reg  = 1'b0;
            mode_reg  = 2'd0;
            errors    = 0;
            drop_tile();
        endfunction

        function void drop_tile();
            fill    = 0;
            visible = 1'b0;
            opaque  = 1'b1;
            partial = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_CELL_PIXELS: cell_reg  = val[6:0];
                CFG_TABLE_LIMIT: limit_reg = val[8:0];
                CFG_ATTR_ENABLE: attr_reg  = val[0];
                CFG_NO_COMPARE:  mode_reg  = val[1:0];
                default: ;
            endcase
        endfunction

        function void note_request(bit op_in, bit [31:0] px);
            int unsigned  cp, lim, n, i;
            bit [7:0]     alpha;
            bit           same;
            tile_result_t res;
            if (op_in == OP_RESTART) begin
                stored = 1;
                drop_tile();
                return;
            end
            cp  = (cell_reg == 0) ? 1 : (cell_reg > CELL_MAX) ? CELL_MAX : cell_reg;
            lim = (limit_reg > SLOTS) ? SLOTS : limit_reg;
            if (fill < CELL_MAX) stage[fill] = px;
            alpha = px[31:24];
            if (alpha != 0) begin
                visible = 1'b1;
                if (alpha != ALPHA_OPAQUE) begin
                    opaque  = 1'b0;
                    partial = 1'b1;
                end
            end else begin
                opaque = 1'b0;
            end
            fill++;
            if (fill < cp) return;
            res = '0;
            if (mode_reg == 0) begin
                for (n = 0; n < stored && n < SLOTS; n++) begin
                    same = 1'b1;
                    for (i = 0; i < cp; i++)
                        if (slot_px[n][i] != stage[i]) same = 1'b0;
                    if (same) begin
                        res.code = slot_code[n];
                        pending_codes.push_back(res);
                        drop_tile();
                        return;
                    end
                end
            end
            if (!visible && !mode_reg[1]) begin
                pending_codes.push_back(res);
                drop_tile();
                return;
            end
            n = stored;
            if (n >= lim || n >= SLOTS) begin
                res.overflow = 1'b1;
                pending_codes.push_back(res);
                drop_tile();
                return;
            end
            for (i = 0; i < CELL_MAX; i++) slot_px[n][i] = (i < cp) ? stage[i] : '0;
            res.code = n[13:0];
            if (attr_reg) begin
                res.code[15] = opaque;
                res.code[14] = partial;
            end
            slot_code[n] = res.code;
            stored = n + 1;
            pending_codes.push_back(res);
            drop_tile();
        endfunction

        function void check_result(logic [15:0] code, logic ovf);
            tile_result_t exp_res;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected tile code %h overflow %b", $time, code, ovf);
                errors++;
                return;
            end
            exp_res = pending_codes.pop_front();
            if (code !== exp_res.code) begin
                $display("%0t: tile_code expected %h actual %h", $time, exp_res.code, code);
                errors++;
            end
            if (ovf !== exp_res.overflow) begin
                $display("%0t: table_overflow expected %b actual %b",
                         $time, exp_res.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 op = 1'b0;
    logic [31:0]          pixel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [15:0]          tile_code;
    logic                 table_overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    tile_code_board board = new();
    int               sent = 0;
    bit               calm = 1'b0;
    bit [31:0]        palette[4];

    tile_dedup_table u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .tile_code(tile_code), .table_overflow(table_overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        if (calm) return 0;
        return ($urandom_range(0, 99) < 12) ? $urandom_range(1, 5) : 0;
    endfunction

    // result side: check at the edge, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(tile_code, table_overflow);
        out_ready <= rst_n && (gap_len() == 0);
    end

    task automatic send_request(bit op_in, bit [31:0] px);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_in;
        pixel    <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(op_in, px);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_codes.size() != 0) @(posedge clk);
        // extra idle time after the last tile code is checked
        repeat (2 * CELL_MAX + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, CFG_DAT_W'(val));
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [31:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom;
        return palette[$urandom_range(0, 3)];
    endfunction

    task automatic random_phase();
        int r, items;
        r = $urandom_range(0, 99);
        if (r < 70)      write_reg(CFG_CELL_PIXELS, $urandom_range(1, 4));
        else if (r < 85) write_reg(CFG_CELL_PIXELS, $urandom_range(5, 16));
        else if (r < 90) write_reg(CFG_CELL_PIXELS, CELL_MAX);
        else if (r < 95) write_reg(CFG_CELL_PIXELS, 0);
        else             write_reg(CFG_CELL_PIXELS, $urandom_range(65, 127));
        r = $urandom_range(0, 99);
        if (r < 50)      write_reg(CFG_TABLE_LIMIT, $urandom_range(2, 20));
        else if (r < 75) write_reg(CFG_TABLE_LIMIT, SLOTS);
        else if (r < 85) write_reg(CFG_TABLE_LIMIT, $urandom_range(0, 1));
        else             write_reg(CFG_TABLE_LIMIT, $urandom_range(257, 511));
        write_reg(CFG_ATTR_ENABLE, $urandom_range(0, 1));
        write_reg(CFG_NO_COMPARE, ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 3));
        foreach (palette[k])
        begin
            case ($urandom_range(0, 3))
                0: palette[k] = {8'h00, 24'($urandom)};
                1: palette[k] = {ALPHA_OPAQUE, 24'($urandom_range(0, 3))};
                2: palette[k] = {8'($urandom_range(1, 254)), 24'($urandom_range(0, 3))};
                default: palette[k] = '0;
            endcase
        end
        if ($urandom_range(0, 1)) send_request(OP_RESTART, $urandom);
        items = (board.cell_reg > 16) ? $urandom_range(64, 200) : $urandom_range(20, 80);
        repeat (items)
        begin
            if ($urandom_range(0, 99) < 3) send_request(OP_RESTART, $urandom);
            else send_request(OP_PIXEL, pick_pixel());
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-pixel tiles
        write_reg(CFG_CELL_PIXELS, 1);
        send_request(OP_PIXEL, 32'h0000_0000);   // matches the blank entry
        send_request(OP_PIXEL, 32'hFFFF_FFFF);   // new
        send_request(OP_PIXEL, 32'h0100_0000);   // new, faint alpha
        send_request(OP_PIXEL, 32'hFFFF_FFFF);   // duplicate
        send_request(OP_PIXEL, 32'h00AB_CDEF);   // invisible, not stored
        send_request(OP_RESTART, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_ATTR_ENABLE, 1);
        send_request(OP_PIXEL, 32'hFF12_3456);
        send_request(OP_PIXEL, 32'h8012_3456);
        send_request(OP_PIXEL, 32'hFE00_0001);
        drain();
        write_reg(CFG_NO_COMPARE, 2);            // keep blank tiles
        send_request(OP_PIXEL, 32'h0000_0000);
        drain();
        write_reg(CFG_NO_COMPARE, 1);            // search off, duplicates stored
        send_request(OP_PIXEL, 32'hFF12_3456);
        drain();
        write_reg(CFG_TABLE_LIMIT, 2);           // already full
        write_reg(CFG_NO_COMPARE, 0);
        send_request(OP_PIXEL, 32'h7700_0000);
        send_request(OP_PIXEL, 32'hFF12_3456);
        drain();
        write_reg(CFG_TABLE_LIMIT, 0);
        write_reg(CFG_CELL_PIXELS, 0);           // acts as one pixel
        send_request(OP_PIXEL, 32'h4242_4242);
        send_request(OP_RESTART, 32'h0);
        drain();
        // cell size shrinks mid-tile
        write_reg(CFG_TABLE_LIMIT, 511);
        write_reg(CFG_CELL_PIXELS, 4);
        send_request(OP_PIXEL, 32'hFF00_0001);
        send_request(OP_PIXEL, 32'h0000_0002);
        drain();
        write_reg(CFG_CELL_PIXELS, 2);
        send_request(OP_PIXEL, 32'h8000_0003);
        send_request(OP_PIXEL, 32'hFF00_0001);
        send_request(OP_PIXEL, 32'h0000_0002);
        drain();

        while (sent < 1200)
        begin
            calm = (sent > 400 && sent < 650);
            random_phase();
        end
        calm = 1'b0;
        drain();
        if (board.errors == 0 && board.pending_codes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
